@@ hw/rtl/serial_frame_receiver_macros.svh @@
// assertion helpers for the frame receiver
// each check is sampled on the rising clock and held off while reset is low
`ifndef SERIAL_FRAME_RECEIVER_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// next-cycle implication
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`endif

@@ hw/rtl/sfr_pkg.sv @@
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CfgIdxW = 3;

    // header bytes counted into the length field
    localparam logic [ByteW-1:0] HeaderBytes  = 8'd10;
    localparam logic [ByteW-1:0] CsumXor      = 8'hFF;
    localparam logic [ByteW-1:0] CsumAdd      = 8'h01;
    localparam logic [ByteW-1:0] TickMax      = 8'hFF;
    localparam logic [ByteW-1:0] TickStart    = 8'h01;
    localparam logic [ByteW-1:0] TimeoutReset = 8'd2;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_HEAD     = 3'd0,
        CFG_TYPE     = 3'd1,
        CFG_RES_HIGH = 3'd2,
        CFG_RES_LOW  = 3'd3,
        CFG_VER_HIGH = 3'd4,
        CFG_VER_LOW  = 3'd5,
        CFG_TIMEOUT  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ABORT_NONE    = 3'd0,
        ABORT_TYPE    = 3'd1,
        ABORT_HCHK    = 3'd2,
        ABORT_FIXED   = 3'd3,
        ABORT_TIMEOUT = 3'd4
    } t_abort;

    typedef struct packed {
        logic [ByteW-1:0] head_value;
        logic [ByteW-1:0] type_value;
        logic [ByteW-1:0] reserved_high_value;
        logic [ByteW-1:0] reserved_low_value;
        logic [ByteW-1:0] version_high_value;
        logic [ByteW-1:0] version_low_value;
        logic [ByteW-1:0] timeout_limit;
    } t_cfg;

    typedef struct packed {
        logic             body_valid;
        logic [ByteW-1:0] body_byte;
        logic [ByteW-1:0] body_index;
        logic             frame_end;
        logic             frame_ok;
        logic [ByteW-1:0] message_id;
        logic [ByteW-1:0] command;
        t_abort           abort_code;
    } t_result;

endpackage

@@ hw/rtl/sfr_channels.sv @@
`timescale 1ns / 1ps

interface sfr_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface sfr_result_if;
    logic       valid;
    logic       ready;
    logic       body_valid;
    logic [7:0] body_byte;
    logic [7:0] body_index;
    logic       frame_end;
    logic       frame_ok;
    logic [7:0] message_id;
    logic [7:0] command;
    logic [2:0] abort_code;

    modport source (
        output valid, output body_valid, output body_byte, output body_index,
        output frame_end, output frame_ok, output message_id, output command,
        output abort_code, input ready
    );
    modport sink (
        input valid, input body_valid, input body_byte, input body_index,
        input frame_end, input frame_ok, input message_id, input command,
        input abort_code, output ready
    );
endinterface

interface sfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/sfr_cfg_regs.sv @@
`timescale 1ns / 1ps

module sfr_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sfr_cfg_if.sink         i_cfg,
    output sfr_pkg::t_cfg   o_cfg
);

    sfr_pkg::t_cfg r_cfg;

    // writes are never stalled: ready is tied high
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{
                head_value:          8'd0,
                type_value:          8'd0,
                reserved_high_value: 8'd0,
                reserved_low_value:  8'd0,
                version_high_value:  8'd0,
                version_low_value:   8'd0,
                timeout_limit:       sfr_pkg::TimeoutReset
            };
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sfr_pkg::CFG_HEAD:     r_cfg.head_value          <= i_cfg.data;
                sfr_pkg::CFG_TYPE:     r_cfg.type_value          <= i_cfg.data;
                sfr_pkg::CFG_RES_HIGH: r_cfg.reserved_high_value <= i_cfg.data;
                sfr_pkg::CFG_RES_LOW:  r_cfg.reserved_low_value  <= i_cfg.data;
                sfr_pkg::CFG_VER_HIGH: r_cfg.version_high_value  <= i_cfg.data;
                sfr_pkg::CFG_VER_LOW:  r_cfg.version_low_value   <= i_cfg.data;
                sfr_pkg::CFG_TIMEOUT:  r_cfg.timeout_limit       <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

@@ hw/rtl/sfr_deframer.sv @@
`timescale 1ns / 1ps

module sfr_deframer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_action,
    input  logic [7:0]        i_rx_byte,
    input  sfr_pkg::t_cfg     i_cfg,
    output sfr_pkg::t_result  o_result
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_LEN   = 4'd1,
        PH_TYPE  = 4'd2,
        PH_HCHK  = 4'd3,
        PH_RESH  = 4'd4,
        PH_RESL  = 4'd5,
        PH_MSGID = 4'd6,
        PH_VERH  = 4'd7,
        PH_VERL  = 4'd8,
        PH_CMD   = 4'd9,
        PH_BODY  = 4'd10,
        PH_CSUM  = 4'd11
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] body_remaining;
        logic [7:0] body_count;
        logic [7:0] header_check;
        logic [7:0] running_sum;
        logic [7:0] held_message_id;
        logic [7:0] held_command;
        logic [7:0] tick_count;
    } t_frame_state;

    localparam t_frame_state StClear = '{
        phase:           PH_IDLE,
        body_remaining:  8'd0,
        body_count:      8'd0,
        header_check:    8'd0,
        running_sum:     8'd0,
        held_message_id: 8'd0,
        held_command:    8'd0,
        tick_count:      8'd0
    };

    t_frame_state r_st;
    t_frame_state n_st;
    logic [7:0]   tick_next;
    logic [7:0]   sum_plus;
    logic [7:0]   rem_dec;
    logic [7:0]   csum_expect;

    assign tick_next   = (r_st.tick_count != sfr_pkg::TickMax) ?
                         r_st.tick_count + 8'd1 : r_st.tick_count;
    assign sum_plus    = r_st.running_sum + i_rx_byte;
    assign rem_dec     = r_st.body_remaining - 8'd1;
    assign csum_expect = (r_st.running_sum ^ sfr_pkg::CsumXor) + sfr_pkg::CsumAdd;

    always_comb begin
        n_st     = r_st;
        o_result = '0;
        if (i_action) begin
            if (r_st.tick_count != 8'd0) begin
                n_st.tick_count = tick_next;
                if (tick_next > i_cfg.timeout_limit) begin
                    n_st                = StClear;
                    o_result.abort_code = sfr_pkg::ABORT_TIMEOUT;
                end
            end
        end else begin
            case (r_st.phase)
                PH_IDLE: begin
                    if (i_rx_byte == i_cfg.head_value) begin
                        n_st            = StClear;
                        n_st.tick_count = sfr_pkg::TickStart;
                        n_st.phase      = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_st.running_sum    = sum_plus;
                    n_st.header_check   = i_rx_byte;
                    n_st.body_remaining = i_rx_byte - sfr_pkg::HeaderBytes;
                    n_st.body_count     = 8'd0;
                    n_st.phase          = PH_TYPE;
                end
                PH_TYPE: begin
                    if (i_rx_byte == i_cfg.type_value) begin
                        n_st.header_check = r_st.header_check ^ i_rx_byte;
                        n_st.running_sum  = sum_plus;
                        n_st.phase        = PH_HCHK;
                    end else begin
                        n_st                = StClear;
                        o_result.abort_code = sfr_pkg::ABORT_TYPE;
                    end
                end
                PH_HCHK: begin
                    if (i_rx_byte == r_st.header_check) begin
                        n_st.running_sum = sum_plus;
                        n_st.phase       = PH_RESH;
                    end else begin
                        n_st                = StClear;
                        o_result.abort_code = sfr_pkg::ABORT_HCHK;
                    end
                end
                PH_RESH: begin
                    if (i_rx_byte == i_cfg.reserved_high_value) begin
                        n_st.running_sum = sum_plus;
                        n_st.phase       = PH_RESL;
                    end else begin
                        n_st                = StClear;
                        o_result.abort_code = sfr_pkg::ABORT_FIXED;
                    end
                end
                PH_RESL: begin
                    if (i_rx_byte == i_cfg.reserved_low_value) begin
                        n_st.running_sum = sum_plus;
                        n_st.phase       = PH_MSGID;
                    end else begin
                        n_st                = StClear;
                        o_result.abort_code = sfr_pkg::ABORT_FIXED;
                    end
                end
                PH_MSGID: begin
                    n_st.running_sum     = sum_plus;
                    n_st.held_message_id = i_rx_byte;
                    n_st.phase           = PH_VERH;
                end
                PH_VERH: begin
                    if (i_rx_byte == i_cfg.version_high_value) begin
                        n_st.running_sum = sum_plus;
                        n_st.phase       = PH_VERL;
                    end else begin
                        n_st                = StClear;
                        o_result.abort_code = sfr_pkg::ABORT_FIXED;
                    end
                end
                PH_VERL: begin
                    if (i_rx_byte == i_cfg.version_low_value) begin
                        n_st.running_sum = sum_plus;
                        n_st.phase       = PH_CMD;
                    end else begin
                        n_st                = StClear;
                        o_result.abort_code = sfr_pkg::ABORT_FIXED;
                    end
                end
                PH_CMD: begin
                    n_st.running_sum  = sum_plus;
                    n_st.held_command = i_rx_byte;
                    // empty body goes straight to the checksum
                    n_st.phase = (r_st.body_remaining != 8'd0) ? PH_BODY : PH_CSUM;
                end
                PH_BODY: begin
                    o_result.body_valid = 1'b1;
                    o_result.body_byte  = i_rx_byte;
                    o_result.body_index = r_st.body_count;
                    n_st.body_count     = r_st.body_count + 8'd1;
                    n_st.running_sum    = sum_plus;
                    n_st.body_remaining = rem_dec;
                    if (rem_dec == 8'd0) begin
                        n_st.phase = PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    o_result.frame_end  = 1'b1;
                    o_result.frame_ok   = (csum_expect == i_rx_byte);
                    o_result.message_id = r_st.held_message_id;
                    o_result.command    = r_st.held_command;
                    n_st                = StClear;
                end
                default: begin
                    n_st = StClear;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StClear;
        end else if (i_accept) begin
            r_st <= n_st;
        end
    end

endmodule

@@ hw/rtl/sfr_out_reg.sv @@
`timescale 1ns / 1ps

module sfr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sfr_pkg::t_result  i_result,
    input  logic              i_taken,
    output logic              o_space,
    output logic              o_valid,
    output sfr_pkg::t_result  o_result
);

    logic             r_valid;
    sfr_pkg::t_result r_result;

    // room when empty or when the held beat leaves this cycle
    assign o_space  = !r_valid || i_taken;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_taken) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ hw/rtl/serial_frame_receiver.sv @@
// serial_frame_receiver: one result beat for every input beat, byte or tick
// latency: the result beat is valid in the cycle after the input beat is taken
// throughput: one input beat per cycle, set by the single output register
// the input stalls only while the output register is full and not taken
// reset (i_rst_n low, synchronous): frame state idle, registers to defaults
// (timeout_limit 2, all others 0), output register empty
`timescale 1ns / 1ps
`include "serial_frame_receiver_macros.svh"

module serial_frame_receiver (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sfr_item_if.sink       i_item,
    sfr_result_if.source   o_result,
    sfr_cfg_if.sink        i_cfg
);

    sfr_pkg::t_cfg    cfg;
    sfr_pkg::t_result step_result;
    sfr_pkg::t_result held_result;
    logic             in_accept;
    logic             out_space;
    logic             out_valid;
    logic             out_taken;
    logic             out_abort;

    // expected-field and timeout registers
    sfr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // a beat enters whenever the output register has room
    assign i_item.ready = out_space;
    assign in_accept    = i_item.valid && out_space;
    assign out_taken    = out_valid && o_result.ready;

    // frame state machine and per-beat result logic
    sfr_deframer u_deframer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_action  (i_item.action),
        .i_rx_byte (i_item.rx_byte),
        .i_cfg     (cfg),
        .o_result  (step_result)
    );

    // result register parts the input side from a stalled sink
    sfr_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_accept),
        .i_result (step_result),
        .i_taken  (out_taken),
        .o_space  (out_space),
        .o_valid  (out_valid),
        .o_result (held_result)
    );

    // result beat fields
    assign o_result.valid      = out_valid;
    assign o_result.body_valid = held_result.body_valid;
    assign o_result.body_byte  = held_result.body_byte;
    assign o_result.body_index = held_result.body_index;
    assign o_result.frame_end  = held_result.frame_end;
    assign o_result.frame_ok   = held_result.frame_ok;
    assign o_result.message_id = held_result.message_id;
    assign o_result.command    = held_result.command;
    assign o_result.abort_code = held_result.abort_code;

    // held beat carries an abort
    assign out_abort = (o_result.abort_code != sfr_pkg::ABORT_NONE);

    // a taken input beat always leaves a result beat behind
    `SFR_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, in_accept, o_result.valid)

    // a held result that is not taken blocks the input side
    `SFR_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n, o_result.valid && !o_result.ready, !i_item.ready)

    // a body byte, a frame end and an abort never share a beat
    `SFR_ASSERT_NOW(a_result_exclusive, i_clk, i_rst_n, o_result.valid, $onehot0({o_result.body_valid, o_result.frame_end, out_abort}))

    // checksum pass is only reported at frame end
    `SFR_ASSERT_NOW(a_ok_needs_end, i_clk, i_rst_n, o_result.valid && o_result.frame_ok, o_result.frame_end)

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

    // watchdog bound, far above the slowest legal run
    localparam int CycleLimit = 200000;

    // canned results that can be read straight off the frame format
    localparam sfr_pkg::t_result R_NONE = '0;
    localparam sfr_pkg::t_result R_TYPE = '{1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00,
                                            sfr_pkg::ABORT_TYPE};
    localparam sfr_pkg::t_result R_HCHK = '{1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00,
                                            sfr_pkg::ABORT_HCHK};
    localparam sfr_pkg::t_result R_TOUT = '{1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 8'h00,
                                            sfr_pkg::ABORT_TIMEOUT};
    localparam sfr_pkg::t_result R_DONE = '{1'b0, 8'h00, 8'h00, 1'b1, 1'b1, 8'h7E, 8'h81,
                                            sfr_pkg::ABORT_NONE};

    // deframer phases, our own copy of the frame walk
    typedef enum logic [3:0] {
        HUNT, GET_LEN, GET_TYPE, GET_HCHK, GET_RESH, GET_RESL,
        GET_ID, GET_VERH, GET_VERL, GET_CMD, GET_BODY, GET_CSUM
    } t_frame_phase;

    // one row of the directed table: a register write or an input beat
    typedef struct {
        logic              is_cfg;
        sfr_pkg::t_cfg_idx idx;
        logic [7:0]        data;
        logic              act;
        logic [7:0]        rx;
        logic              typed;
        sfr_pkg::t_result  want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic sink_ready = 1'b0;

    sfr_item_if   item_bus ();
    sfr_result_if res_bus ();
    sfr_cfg_if    cfg_bus ();

    assign res_bus.ready = sink_ready;

    serial_frame_receiver DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (res_bus),
        .i_cfg    (cfg_bus)
    );

    // 20 ns period
    always #10 i_clk = ~i_clk;

    // predictor state: register shadow plus the frame walk
    sfr_pkg::t_cfg reg_shadow;
    t_frame_phase  rx_phase;
    logic [7:0]    body_left;
    logic [7:0]    body_pos;
    logic [7:0]    hdr_check;
    logic [7:0]    csum_acc;
    logic [7:0]    held_id;
    logic [7:0]    held_cmd;
    logic [7:0]    tick_cnt;

    // results still owed by the block, oldest first
    sfr_pkg::t_result pending_results[$];

    int mismatches = 0;
    int beats_sent = 0;
    int results_seen = 0;
    int frames_sent = 0;
    int cycle_cnt = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    sfr_pkg::t_result mon_got;
    sfr_pkg::t_result mon_want;
    sfr_pkg::t_cfg    phase_cfg;
    t_dir_row         dir_rows [31];

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // back to hunting, as after reset or any abort
    function automatic void clear_frame();
        rx_phase  = HUNT;
        body_left = '0;
        body_pos  = '0;
        hdr_check = '0;
        csum_acc  = '0;
        held_id   = '0;
        held_cmd  = '0;
        tick_cnt  = '0;
    endfunction

    // a fixed field either matches and advances or kills the frame
    function automatic void match_fixed(input logic [7:0] b, input logic [7:0] want,
                                        input t_frame_phase nxt,
                                        input sfr_pkg::t_abort code,
                                        inout sfr_pkg::t_result r);
        if (b == want) begin
            csum_acc = csum_acc + b;
            rx_phase = nxt;
        end else begin
            clear_frame();
            r.abort_code = code;
        end
    endfunction

    // one input beat in, the result beat it should produce out
    function automatic sfr_pkg::t_result deframe_step(input logic act, input logic [7:0] b);
        sfr_pkg::t_result r;
        logic [7:0]       want_csum;
        r = '0;
        // timer tick: only counts while a frame is open
        if (act) begin
            if (tick_cnt != '0) begin
                if (tick_cnt != sfr_pkg::TickMax) tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt > reg_shadow.timeout_limit) begin
                    clear_frame();
                    r.abort_code = sfr_pkg::ABORT_TIMEOUT;
                end
            end
            return r;
        end
        case (rx_phase)
            HUNT: begin
                if (b == reg_shadow.head_value) begin
                    clear_frame();
                    tick_cnt = sfr_pkg::TickStart;
                    rx_phase = GET_LEN;
                end
            end
            GET_LEN: begin
                csum_acc  = csum_acc + b;
                hdr_check = b;
                body_left = b - sfr_pkg::HeaderBytes;
                body_pos  = '0;
                rx_phase  = GET_TYPE;
            end
            GET_TYPE: begin
                if (b == reg_shadow.type_value) hdr_check = hdr_check ^ b;
                match_fixed(b, reg_shadow.type_value, GET_HCHK, sfr_pkg::ABORT_TYPE, r);
            end
            GET_HCHK: match_fixed(b, hdr_check, GET_RESH, sfr_pkg::ABORT_HCHK, r);
            GET_RESH: match_fixed(b, reg_shadow.reserved_high_value, GET_RESL,
                                  sfr_pkg::ABORT_FIXED, r);
            GET_RESL: match_fixed(b, reg_shadow.reserved_low_value, GET_ID,
                                  sfr_pkg::ABORT_FIXED, r);
            GET_ID: begin
                csum_acc = csum_acc + b;
                held_id  = b;
                rx_phase = GET_VERH;
            end
            GET_VERH: match_fixed(b, reg_shadow.version_high_value, GET_VERL,
                                  sfr_pkg::ABORT_FIXED, r);
            GET_VERL: match_fixed(b, reg_shadow.version_low_value, GET_CMD,
                                  sfr_pkg::ABORT_FIXED, r);
            GET_CMD: begin
                csum_acc = csum_acc + b;
                held_cmd = b;
                rx_phase = (body_left != '0) ? GET_BODY : GET_CSUM;
            end
            GET_BODY: begin
                r.body_valid = 1'b1;
                r.body_byte  = b;
                r.body_index = body_pos;
                body_pos  = body_pos + 8'd1;
                csum_acc  = csum_acc + b;
                body_left = body_left - 8'd1;
                if (body_left == '0) rx_phase = GET_CSUM;
            end
            GET_CSUM: begin
                want_csum    = (csum_acc ^ sfr_pkg::CsumXor) + sfr_pkg::CsumAdd;
                r.frame_end  = 1'b1;
                r.frame_ok   = (want_csum == b);
                r.message_id = held_id;
                r.command    = held_cmd;
                clear_frame();
            end
            default: clear_frame();
        endcase
        return r;
    endfunction

    function automatic string fmt_result(input sfr_pkg::t_result r);
        return $sformatf("bv=%0d byte=%02h idx=%0d end=%0d ok=%0d id=%02h cmd=%02h abort=%0d",
                         r.body_valid, r.body_byte, r.body_index, r.frame_end,
                         r.frame_ok, r.message_id, r.command, r.abort_code);
    endfunction

    task automatic flag_miss(input string what, input sfr_pkg::t_result want,
                             input sfr_pkg::t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected %s | actual %s",
                     what, fmt_result(want), fmt_result(got));
    endtask

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // push one beat through the item channel, then predict its result
    // typed rows carry their own answer, the predictor still advances
    task automatic send_beat(input logic act, input logic [7:0] b,
                             input logic typed, input sfr_pkg::t_result want);
        sfr_pkg::t_result guess;
        // random sender gaps, valid held low
        while ($urandom_range(99) < send_idle_pct) begin
            item_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.action  <= act;
        item_bus.rx_byte <= b;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        guess = deframe_step(act, b);
        pending_results.push_back(typed ? want : guess);
        beats_sent++;
    endtask

    // register write, only once the block has drained
    task automatic write_reg(input sfr_pkg::t_cfg_idx idx, input logic [7:0] v);
        item_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= v;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        case (idx)
            sfr_pkg::CFG_HEAD:     reg_shadow.head_value          = v;
            sfr_pkg::CFG_TYPE:     reg_shadow.type_value          = v;
            sfr_pkg::CFG_RES_HIGH: reg_shadow.reserved_high_value = v;
            sfr_pkg::CFG_RES_LOW:  reg_shadow.reserved_low_value  = v;
            sfr_pkg::CFG_VER_HIGH: reg_shadow.version_high_value  = v;
            sfr_pkg::CFG_VER_LOW:  reg_shadow.version_low_value   = v;
            sfr_pkg::CFG_TIMEOUT:  reg_shadow.timeout_limit       = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_regs(input sfr_pkg::t_cfg c);
        write_reg(sfr_pkg::CFG_HEAD,     c.head_value);
        write_reg(sfr_pkg::CFG_TYPE,     c.type_value);
        write_reg(sfr_pkg::CFG_RES_HIGH, c.reserved_high_value);
        write_reg(sfr_pkg::CFG_RES_LOW,  c.reserved_low_value);
        write_reg(sfr_pkg::CFG_VER_HIGH, c.version_high_value);
        write_reg(sfr_pkg::CFG_VER_LOW,  c.version_low_value);
        write_reg(sfr_pkg::CFG_TIMEOUT,  c.timeout_limit);
    endtask

    // one frame against the current registers, often well formed
    // flaws: bad type, bad header check, bad reserved/version, leading noise,
    // bad checksum, truncation, and a stall long enough to time out
    task automatic send_frame(input int tick_pct, input logic long_body);
        logic [7:0] frame_bytes[$];
        logic [7:0] len;
        logic [7:0] typ;
        logic [7:0] body_len;
        logic [7:0] sum;
        int         flaw;
        int         head_at;
        int         slot;
        int         n_send;
        int         stall_at;
        flaw = long_body ? 99 : $urandom_range(0, 11);
        // a length below ten wraps into a body of 246..255 bytes
        len = long_body ? 8'($urandom_range(0, 9)) : 8'($urandom_range(10, 24));
        typ = reg_shadow.type_value;
        if (flaw == 0) typ = typ ^ 8'($urandom_range(1, 255));
        if (flaw == 3) repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
        head_at = frame_bytes.size();
        frame_bytes.push_back(reg_shadow.head_value);
        frame_bytes.push_back(len);
        frame_bytes.push_back(typ);
        frame_bytes.push_back(len ^ typ);
        frame_bytes.push_back(reg_shadow.reserved_high_value);
        frame_bytes.push_back(reg_shadow.reserved_low_value);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(reg_shadow.version_high_value);
        frame_bytes.push_back(reg_shadow.version_low_value);
        frame_bytes.push_back(8'($urandom));
        if (flaw == 1) frame_bytes[head_at + 3] ^= 8'($urandom_range(1, 255));
        if (flaw == 2) begin
            // offsets 4, 5, 7, 8: reserved high/low, version high/low
            slot = $urandom_range(0, 3);
            slot = (slot < 2) ? slot + 4 : slot + 5;
            frame_bytes[head_at + slot] ^= 8'($urandom_range(1, 255));
        end
        body_len = len - sfr_pkg::HeaderBytes;
        repeat (body_len) frame_bytes.push_back(8'($urandom));
        sum = '0;
        for (int i = head_at + 1; i < frame_bytes.size(); i++) sum = sum + frame_bytes[i];
        frame_bytes.push_back((flaw == 4) ? ((8'h00 - sum) ^ 8'($urandom_range(1, 255)))
                                          : (8'h00 - sum));
        n_send = frame_bytes.size();
        if (flaw == 5) n_send = $urandom_range(head_at + 2, n_send - 1);
        stall_at = (flaw == 6 && reg_shadow.timeout_limit <= 8'd30)
                 ? $urandom_range(head_at + 1, n_send - 1) : -1;
        for (int i = 0; i < n_send; i++) begin
            if ($urandom_range(99) < tick_pct) send_beat(1'b1, 8'($urandom), 1'b0, R_NONE);
            // from a count of one, limit ticks push it past the limit
            if (i == stall_at)
                repeat (reg_shadow.timeout_limit) send_beat(1'b1, 8'($urandom), 1'b0, R_NONE);
            send_beat(1'b0, frame_bytes[i], 1'b0, R_NONE);
        end
        frames_sent++;
    endtask

    // ---------------------------------------------------------------
    // receiver side
    // ---------------------------------------------------------------

    // random backpressure on the result channel
    always @(posedge i_clk) begin
        sink_ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // every accepted result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            mon_got.body_valid = res_bus.body_valid;
            mon_got.body_byte  = res_bus.body_byte;
            mon_got.body_index = res_bus.body_index;
            mon_got.frame_end  = res_bus.frame_end;
            mon_got.frame_ok   = res_bus.frame_ok;
            mon_got.message_id = res_bus.message_id;
            mon_got.command    = res_bus.command;
            mon_got.abort_code = sfr_pkg::t_abort'(res_bus.abort_code);
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_miss("result beat with nothing pending", R_NONE, mon_got);
            end else begin
                mon_want = pending_results.pop_front();
                if ((mon_got.body_valid !== mon_want.body_valid) ||
                    (mon_got.body_byte  !== mon_want.body_byte)  ||
                    (mon_got.body_index !== mon_want.body_index) ||
                    (mon_got.frame_end  !== mon_want.frame_end)  ||
                    (mon_got.frame_ok   !== mon_want.frame_ok)   ||
                    (mon_got.message_id !== mon_want.message_id) ||
                    (mon_got.command    !== mon_want.command)    ||
                    (mon_got.abort_code !== mon_want.abort_code))
                    flag_miss($sformatf("result beat %0d", results_seen), mon_want, mon_got);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_cnt, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    initial begin
        // every block input known from time zero
        i_rst_n          <= 1'b0;
        item_bus.valid   <= 1'b0;
        item_bus.action  <= 1'b0;
        item_bus.rx_byte <= 8'h00;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= sfr_pkg::CFG_HEAD;
        cfg_bus.data     <= 8'h00;

        // predictor starts from the reset defaults
        reg_shadow = '0;
        reg_shadow.timeout_limit = sfr_pkg::TimeoutReset;
        clear_frame();

        // directed table, fields: cfg?, reg, data, action, byte, typed?, result
        dir_rows = '{
            // defaults after reset: tick while idle, non-head byte while idle
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b1, 8'hFF, 1'b1, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h55, 1'b1, R_NONE},
            // every register once
            '{1'b1, sfr_pkg::CFG_HEAD,     8'hA5, 1'b0, 8'h00, 1'b0, R_NONE},
            '{1'b1, sfr_pkg::CFG_TYPE,     8'h3C, 1'b0, 8'h00, 1'b0, R_NONE},
            '{1'b1, sfr_pkg::CFG_RES_HIGH, 8'h00, 1'b0, 8'h00, 1'b0, R_NONE},
            '{1'b1, sfr_pkg::CFG_RES_LOW,  8'hFF, 1'b0, 8'h00, 1'b0, R_NONE},
            '{1'b1, sfr_pkg::CFG_VER_HIGH, 8'h01, 1'b0, 8'h00, 1'b0, R_NONE},
            '{1'b1, sfr_pkg::CFG_VER_LOW,  8'h02, 1'b0, 8'h00, 1'b0, R_NONE},
            '{1'b1, sfr_pkg::CFG_TIMEOUT,  8'hFE, 1'b0, 8'h00, 1'b0, R_NONE},
            // empty body frame with a tick while open, good checksum
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'hA5, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h0A, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b1, 8'h00, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h3C, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h36, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h00, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'hFF, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h7E, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h01, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h02, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h81, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h83, 1'b1, R_DONE},
            // wrong type byte
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'hA5, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h0A, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h3D, 1'b1, R_TYPE},
            // wrong header check
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'hA5, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h0A, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h3C, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'h00, 1'b1, R_HCHK},
            // limit of one: a single tick after the head times out
            '{1'b1, sfr_pkg::CFG_TIMEOUT,  8'h01, 1'b0, 8'h00, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b0, 8'hA5, 1'b0, R_NONE},
            '{1'b0, sfr_pkg::CFG_HEAD,     8'h00, 1'b1, 8'h5A, 1'b1, R_TOUT}
        };

        // sender 23 percent idle, receiver 64
        send_idle_pct = 23;
        recv_idle_pct = 64;

        // hold reset low for a while, then release it
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            else
                send_beat(dir_rows[i].act, dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);
        end

        // phase 0: extreme register values, longest timeout
        phase_cfg = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFE};
        load_regs(phase_cfg);
        while (beats_sent < 200) send_frame(10, 1'b0);

        // phase 1: roles swapped, random registers, any open tick aborts
        send_idle_pct = 64;
        recv_idle_pct = 23;
        phase_cfg = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'h01};
        load_regs(phase_cfg);
        while (beats_sent < 370) send_frame(3, 1'b0);

        // phase 2: no idling, short timeouts, one wrapped long body
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase_cfg = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom_range(2, 24))};
        load_regs(phase_cfg);
        send_frame(0, 1'b1);
        while (beats_sent < 650) send_frame(8, 1'b0);

        // drain, then wait with no input for any stray beat
        item_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatches += pending_results.size();
            $display("%0d predicted results never arrived", pending_results.size());
        end

        $display("ran %0d input beats in %0d random frames plus the directed table, %0d results",
                 beats_sent, frames_sent, results_seen);
        $display("three pacing mixes, timeout limits 254, 1 and %0d, %0d mismatches",
                 reg_shadow.timeout_limit, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
